// ===== rtl/fixed_point_math_unit_top_macros.svh =====
// assertion macros for the fixed-point math unit
`ifndef FIXED_POINT_MATH_UNIT_TOP_MACROS_SVH
`define FIXED_POINT_MATH_UNIT_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define FXM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fxm same-cycle check failed");
// next-cycle implication, checked outside reset
`define FXM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fxm next-cycle check failed");
`else
`define FXM_ASSERT_SAME(label, clk, rst, ante, cons)
`define FXM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/fxm_pkg.sv =====
// shared types, operation codes and elaboration-time helpers of the math unit
`default_nettype none
package fxm_pkg;

  // operation codes
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_SQRT = 2'd1;
  localparam logic [1:0] OP_EXP2 = 2'd2;
  localparam logic [1:0] OP_LOG2 = 2'd3;

  // command beat as seen by the sequencer
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } fxm_cmd_t;

  // finished result handed to the output register
  typedef struct packed {
    logic [31:0] result;
    logic        overflow;
  } fxm_res_t;

  // sequencer status
  typedef struct packed {
    logic idle;
    logic done;
  } fxm_stat_t;

  // number of significant bits, used for constants only
  function automatic int fxm_bit_len(input logic [63:0] p);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (p[i]) n = i + 1;
    end
    return n;
  endfunction

  // floored fixed-point square root, used for constants only
  function automatic logic [63:0] fxm_sqrt_fn(input logic [63:0] x, input int frac);
    logic [63:0] acc;
    logic [63:0] bitv;
    logic [63:0] sq;
    int          ib;
    acc = '0;
    if (x == '0) return '0;
    ib = fxm_bit_len(x);
    ib = (ib > frac) ? ib - frac : 0;
    ib = ib >> 1;
    bitv = 64'd1 << (frac + ib);
    for (int i = 0; i < 64; i++) begin
      if (bitv != '0) begin
        acc = acc | bitv;
        sq = (acc * acc) >> frac;
        if (sq > x) acc = acc ^ bitv;
        bitv = bitv >> 1;
      end
    end
    return acc;
  endfunction

  // 2.0 after k successive square roots, used for constants only
  function automatic logic [63:0] fxm_root_fn(input int frac, input int k);
    logic [63:0] root;
    root = 64'd2 << frac;
    for (int i = 0; i < 16; i++) begin
      if (i < k) root = fxm_sqrt_fn(root, frac);
    end
    return root;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fxm_cmd_if.sv =====
// command channel: operation and operands
`default_nettype none
interface fxm_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input operation, input operand_a, input operand_b,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/fxm_rsp_if.sv =====
// response channel: result and overflow flag
`default_nettype none
interface fxm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        overflow;

  modport source (output valid, output result, output overflow, input ready);
  modport sink (input valid, input result, input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/fxm_mul.sv =====
// shared unsigned multiplier with registered full-width product
`default_nettype none
module fxm_mul #(
  parameter int MW = 32
) (
  input  logic            clk,
  input  logic [MW-1:0]   a,
  input  logic [MW-1:0]   b,
  output logic [2*MW-1:0] prod
);

  logic [2*MW-1:0] prod_next;

  // full product, zero extended operands
  assign prod_next = {{MW{1'b0}}, a} * {{MW{1'b0}}, b};

  // product register
  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule
`default_nettype wire

// ===== rtl/fxm_seq.sv =====
// sequencer and datapath registers driving the shared multiplier
`default_nettype none
module fxm_seq
  import fxm_pkg::*;
#(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 3
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  fxm_cmd_t  cmd,
  input  logic      ack,
  output fxm_stat_t stat,
  output fxm_res_t  res
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int MW  = (W >= F + 2) ? W : F + 2;
  localparam int PW  = 2 * MW;
  localparam int PSW = $clog2(W);

  // highest trial bit of the root; anything at or above the word width is always rejected
  localparam int SQ_TOP_I = (F + ((W - F) >> 1) < W - 1) ? F + ((W - F) >> 1) : W - 1;
  // first log2 search bit, clipped to the word
  localparam int L2_BL      = fxm_bit_len(64'(W - F));
  localparam int L2_TOP_I   = F + ((L2_BL > 0) ? L2_BL - 1 : 0);
  localparam int L2_START_I = (L2_TOP_I < W - 1) ? L2_TOP_I : W - 1;

  localparam logic [PSW-1:0] SQ_TOP   = PSW'(SQ_TOP_I);
  localparam logic [PSW-1:0] L2_START = PSW'(L2_START_I);
  localparam logic [PSW-1:0] TOP_POS  = PSW'(W - 1);
  localparam logic [PSW-1:0] F_LAST   = PSW'(F - 1);
  localparam logic [PSW:0]   F_POS    = (PSW + 1)'(F);
  localparam logic [MW-1:0]  FX_ONE   = MW'(1) << F;
  localparam logic [W-1:0]   WORD_MAX = '1;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_ISS = 4'd1;
  localparam logic [3:0] S_MUL_WB  = 4'd2;
  localparam logic [3:0] S_SQ_ISS  = 4'd3;
  localparam logic [3:0] S_SQ_WB   = 4'd4;
  localparam logic [3:0] S_L2_TRY  = 4'd5;
  localparam logic [3:0] S_EI_ISS  = 4'd6;
  localparam logic [3:0] S_EI_WB   = 4'd7;
  localparam logic [3:0] S_EF_CHK  = 4'd8;
  localparam logic [3:0] S_EF_WB   = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]     state, state_next;
  logic [1:0]     op, op_next;
  logic [W-1:0]   xa, xa_next;
  logic [W-1:0]   xb, xb_next;
  logic [PSW-1:0] pos, pos_next;
  logic [PSW-1:0] lpos, lpos_next;
  logic [MW-1:0]  acc, acc_next;
  logic [W-1:0]   y, y_next;
  logic [MW-1:0]  res_val, res_val_next;
  logic           res_ovf, res_ovf_next;

  logic [MW-1:0]  mul_a, mul_b;
  logic [PW-1:0]  prod;
  logic [PW-1:0]  scaled;
  logic [PW-1:0]  int_val;
  logic           over_w;
  logic           int_ovf;
  logic           sq_ok;
  logic [MW-1:0]  trial;
  logic [W-1:0]   lbit;
  logic [MW-1:0]  root_tab [W];

  // roots of 2.0 for each fraction position of the exponent
  for (genvar p = 0; p < W; p++) begin : g_root
    if (p < F) begin : g_frac
      localparam logic [63:0] ROOT = fxm_root_fn(F, F - p);
      assign root_tab[p] = ROOT[MW-1:0];
    end else begin : g_int
      assign root_tab[p] = '0;
    end
  end

  // shared multiplier
  fxm_mul #(
    .MW (MW)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // product evaluation; the root of zero keeps every trial bit clear
  assign trial   = acc | (MW'(1) << pos);
  assign lbit    = W'(1) << lpos;
  assign scaled  = prod >> F;
  assign over_w  = |scaled[PW-1:W];
  assign sq_ok   = !over_w && (scaled[W-1:0] <= xa) && (xa != '0);
  assign int_val = y[pos] ? {scaled[PW-2:0], 1'b0} : scaled;
  assign int_ovf = |int_val[PW-1:W];

  // multiplier operand selection
  always_comb begin
    mul_a = acc;
    mul_b = acc;
    case (state)
      S_MUL_ISS: begin
        mul_a = MW'(xa);
        mul_b = MW'(xb);
      end
      S_SQ_ISS: begin
        mul_a = trial;
        mul_b = trial;
      end
      S_EF_CHK: begin
        mul_b = root_tab[pos];
      end
      default: begin
        mul_a = acc;
        mul_b = acc;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    logic          exp_fin;
    logic          exp_ovf;
    logic [MW-1:0] exp_val;
    logic [MW-1:0] acc_new;
    logic [W-1:0]  y_new;
    state_next   = state;
    op_next      = op;
    xa_next      = xa;
    xb_next      = xb;
    pos_next     = pos;
    lpos_next    = lpos;
    acc_next     = acc;
    y_next       = y;
    res_val_next = res_val;
    res_ovf_next = res_ovf;
    exp_fin      = 1'b0;
    exp_ovf      = 1'b0;
    exp_val      = acc;
    acc_new      = acc;
    y_new        = y;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next = cmd.operation;
          xa_next = cmd.operand_a[W-1:0];
          xb_next = cmd.operand_b[W-1:0];
          unique case (cmd.operation)
            OP_MUL: begin
              state_next = S_MUL_ISS;
            end
            OP_SQRT: begin
              acc_next   = '0;
              pos_next   = SQ_TOP;
              state_next = S_SQ_ISS;
            end
            OP_EXP2: begin
              y_next     = cmd.operand_a[W-1:0];
              acc_next   = FX_ONE;
              pos_next   = TOP_POS;
              state_next = S_EI_ISS;
            end
            OP_LOG2: begin
              y_next     = '0;
              lpos_next  = L2_START;
              state_next = S_L2_TRY;
            end
          endcase
        end
      end
      S_MUL_ISS: begin
        state_next = S_MUL_WB;
      end
      S_MUL_WB: begin
        res_ovf_next = over_w;
        res_val_next = over_w ? MW'(WORD_MAX) : MW'(scaled[W-1:0]);
        state_next   = S_DONE;
      end
      S_SQ_ISS: begin
        state_next = S_SQ_WB;
      end
      S_SQ_WB: begin
        acc_new  = sq_ok ? trial : acc;
        acc_next = acc_new;
        if (pos == '0) begin
          res_val_next = acc_new;
          res_ovf_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          pos_next   = pos - PSW'(1);
          state_next = S_SQ_ISS;
        end
      end
      S_L2_TRY: begin
        y_next     = y | lbit;
        acc_next   = FX_ONE;
        pos_next   = L2_START;
        state_next = S_EI_ISS;
      end
      S_EI_ISS: begin
        // no integer bits left to visit: go straight to the fraction
        if ({1'b0, pos} < F_POS) state_next = S_EF_CHK;
        else                     state_next = S_EI_WB;
      end
      S_EI_WB: begin
        if (int_ovf) begin
          exp_fin = 1'b1;
          exp_ovf = 1'b1;
        end else begin
          acc_next = MW'(int_val[W-1:0]);
          if ({1'b0, pos} == F_POS) begin
            pos_next   = F_LAST;
            state_next = S_EF_CHK;
          end else begin
            pos_next   = pos - PSW'(1);
            state_next = S_EI_ISS;
          end
        end
      end
      S_EF_CHK: begin
        if (y[pos]) begin
          state_next = S_EF_WB;
        end else if (pos == '0) begin
          exp_fin = 1'b1;
          exp_val = acc;
        end else begin
          pos_next = pos - PSW'(1);
        end
      end
      S_EF_WB: begin
        if (over_w) begin
          exp_fin = 1'b1;
          exp_ovf = 1'b1;
        end else begin
          acc_next = MW'(scaled[W-1:0]);
          exp_val  = MW'(scaled[W-1:0]);
          if (pos == '0) begin
            exp_fin = 1'b1;
          end else begin
            pos_next   = pos - PSW'(1);
            state_next = S_EF_CHK;
          end
        end
      end
      S_DONE: begin
        if (ack) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // end of one exp2 evaluation: either the answer or one log2 trial
    if (exp_fin) begin
      if (op == OP_EXP2) begin
        res_val_next = exp_ovf ? MW'(WORD_MAX) : exp_val;
        res_ovf_next = exp_ovf;
        state_next   = S_DONE;
      end else begin
        y_new = y;
        if (exp_ovf || (exp_val > MW'(xa))) y_new = y & ~lbit;
        y_next = y_new;
        if (lpos == '0) begin
          res_val_next = MW'(y_new);
          res_ovf_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          lpos_next  = lpos - PSW'(1);
          state_next = S_L2_TRY;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op      <= op_next;
    xa      <= xa_next;
    xb      <= xb_next;
    pos     <= pos_next;
    lpos    <= lpos_next;
    acc     <= acc_next;
    y       <= y_next;
    res_val <= res_val_next;
    res_ovf <= res_ovf_next;
  end

  // status and result
  assign stat.idle    = (state == S_IDLE);
  assign stat.done    = (state == S_DONE);
  assign res.result   = 32'(res_val);
  assign res.overflow = res_ovf;

endmodule
`default_nettype wire

// ===== rtl/fixed_point_math_unit_top.sv =====
// Unsigned fixed-point math unit: multiply, square root, exp2 and log2.
// One command beat on cmd (operation, operand_a, operand_b) gives one response
// beat on rsp (result, overflow). Values are WORD_BITS wide with FRACTION_BITS
// fraction bits; a result that does not fit is saturated to all ones with
// overflow set. All arithmetic goes through one registered multiplier, stepped
// by a small sequencer, so the unit works on one command at a time and holds
// cmd.ready low until the sequencer is idle again.
// Steps per command: multiply issues to the multiplier, then writes back; square
// root does an issue/write-back pair per root bit from the top root bit down;
// exp2 does a pair per integer bit visited, then a check per fraction bit plus
// a write-back where that bit is set, cut short on overflow; log2 runs an exp2
// evaluation per search bit (8 search bits with defaults 32/3).
// A finished result waits in the output register; the sequencer takes the next
// command while it waits, and holds its own finished result until the register
// frees. A stalled rsp.ready therefore only stalls cmd after one more command.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register; no other state is kept between commands.
`default_nettype none
`include "fixed_point_math_unit_top_macros.svh"
module fixed_point_math_unit_top
  import fxm_pkg::*;
#(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 3
) (
  input  logic clk,
  input  logic rst,
  fxm_cmd_if.sink   cmd,
  fxm_rsp_if.source rsp
);

  localparam logic [31:0] SAT_RESULT = 32'({WORD_BITS{1'b1}});

  fxm_cmd_t  seq_cmd;
  fxm_res_t  seq_res;
  fxm_stat_t stat;
  logic      start;
  logic      ack;
  logic      out_full;
  fxm_res_t  out_res;

  // command beat into the sequencer
  assign seq_cmd.operation = cmd.operation;
  assign seq_cmd.operand_a = cmd.operand_a;
  assign seq_cmd.operand_b = cmd.operand_b;
  assign cmd.ready         = stat.idle;
  assign start             = cmd.valid && stat.idle;

  fxm_seq #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (seq_cmd),
    .ack   (ack),
    .stat  (stat),
    .res   (seq_res)
  );

  // output register takes a result when empty or being drained
  assign ack = stat.done && (!out_full || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (ack) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) out_res <= seq_res;
  end

  assign rsp.valid    = out_full;
  assign rsp.result   = out_res.result;
  assign rsp.overflow = out_res.overflow;

  // checks
  `FXM_ASSERT_NEXT(a_start_busy, clk, rst, start, !stat.idle)
  `FXM_ASSERT_NEXT(a_ack_loads, clk, rst, ack, out_full && stat.idle)
  `FXM_ASSERT_SAME(a_ovf_sat, clk, rst, rsp.valid && rsp.overflow, rsp.result == SAT_RESULT)

endmodule
`default_nettype wire
